// ===== src/ttcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared types and fixed codes of the character-cell text terminal.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

  // Input beat
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] code;
    logic [7:0] repeat_count;
    logic [6:0] read_col;
    logic [5:0] read_row;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [6:0] caret_col;
    logic [5:0] caret_row;
    logic [7:0] cell_value;
  } out_item_t;

  // Item modes
  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_NAV  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Navigation keys
  localparam logic [7:0] KEY_HOME   = 8'd0;
  localparam logic [7:0] KEY_END    = 8'd1;
  localparam logic [7:0] KEY_TOP    = 8'd2;
  localparam logic [7:0] KEY_BOTTOM = 8'd3;
  localparam logic [7:0] KEY_LEFT   = 8'd4;
  localparam logic [7:0] KEY_RIGHT  = 8'd5;
  localparam logic [7:0] KEY_UP     = 8'd6;
  localparam logic [7:0] KEY_DOWN   = 8'd7;
  localparam logic [7:0] KEY_DEL    = 8'd8;

  // Configuration register indexes
  localparam int         CFG_IW   = 2;
  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;

  // Tab stops every 2**TAB_BITS columns
  localparam int TAB_BITS = 3;

  // Operand width of the step unit: holds any column or row count
  localparam int OPW = 9;

  typedef struct packed {
    logic [OPW-1:0] val;
    logic [OPW-1:0] lim;
  } step_op_t;

  typedef struct packed {
    logic [OPW-1:0] inc;     // val + 1
    logic [OPW-1:0] dec;     // val - 1
    logic [OPW-1:0] lim_m1;  // lim - 1
    logic           wrap;    // val + 1 >= lim
    logic           zero;    // val == 0
  } step_res_t;

endpackage

`default_nettype wire

// ===== src/ttcb_ram.sv =====
// ----------------------------------------------------------------------------
// ttcb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/ttcb_step.sv =====
// ----------------------------------------------------------------------------
// ttcb_step
// Shared step unit: increment, decrement and limit compare of one position.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_step (
  input  wire ttcb_pkg::step_op_t  op,
  output ttcb_pkg::step_res_t      res
);

  import ttcb_pkg::*;

  always_comb begin
    res.inc    = op.val + OPW'(1);
    res.dec    = op.val - OPW'(1);
    res.lim_m1 = op.lim - OPW'(1);
    res.wrap   = (op.val + OPW'(1)) >= op.lim;
    res.zero   = (op.val == '0);
  end

endmodule

`default_nettype wire

// ===== src/text_terminal_char_buffer.sv =====
// ----------------------------------------------------------------------------
// text_terminal_char_buffer
// Character-cell text terminal: cell store, caret and a small sequencer.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------
//   input    | start / busy            | in_data  (ttcb_pkg::in_item_t)
//   result   | out_valid (one cycle)   | out_data (ttcb_pkg::out_item_t)
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// busy rises at the accepting edge; the item is decoded, then its result is
// issued. A plain character writes one cell per repeat; a tab repeat writes
// spaces up to the next tab stop; delete and backspace shift the rest of the
// row left, each cell read then written, and pad its end; a read fetches one
// cell. Escape, reset and a column or row register write clear the store one
// cell a cycle. The strobe comes in the first cycle with busy low; the
// receiver cannot stall, and cfg_ready is high only while idle with start low.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_char_buffer #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire ttcb_pkg::in_item_t         in_data,
  output logic                            out_valid,
  output ttcb_pkg::out_item_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [ttcb_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [7:0]                 cfg_data
);

  import ttcb_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int AW  = CW + RW;
  localparam int RST_COLS = (80 > MAX_COLS) ? MAX_COLS : 80;
  localparam int RST_ROWS = (25 > MAX_ROWS) ? MAX_ROWS : 25;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_TAB   = 3'd3;
  localparam logic [2:0] S_SH_RD = 3'd4;
  localparam logic [2:0] S_SH_WR = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]     state_r,    state_nxt;
  logic [CW-1:0]  caret_x_r,  caret_x_nxt;
  logic [RW-1:0]  caret_y_r,  caret_y_nxt;
  logic [CW-1:0]  scan_r,     scan_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [7:0]     reps_r,     reps_nxt;
  in_item_t       item_r,     item_nxt;
  logic [7:0]     cell_r,     cell_nxt;
  logic           res_pend_r, res_pend_nxt;
  logic [CNW-1:0] cols_r,     cols_nxt;
  logic [RNW-1:0] rows_r,     rows_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r,  out_data_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  step_op_t       col_op,  row_op;
  step_res_t      col_res, row_res;

  logic [CW-1:0]  adv_x;
  logic [RW-1:0]  adv_y;
  logic [RW-1:0]  down_y;
  logic           rep_last;
  logic           in_grid;
  logic [CNW-1:0] cols_clamp;
  logic [RNW-1:0] rows_clamp;

  // Cell store
  ttcb_ram #(
    .WIDTH (8),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Step units: column side serves caret and delete scan, row side the caret
  assign col_op.val = (state_r == S_SH_RD || state_r == S_SH_WR) ?
                      OPW'(scan_r) : OPW'(caret_x_r);
  assign col_op.lim = OPW'(cols_r);
  assign row_op.val = OPW'(caret_y_r);
  assign row_op.lim = OPW'(rows_r);

  ttcb_step u_col_step (.op(col_op), .res(col_res));
  ttcb_step u_row_step (.op(row_op), .res(row_res));

  // Caret after one printed cell, and the row after a line feed
  assign down_y = row_res.wrap ? '0 : RW'(row_res.inc);
  assign adv_x  = col_res.wrap ? '0 : CW'(col_res.inc);
  assign adv_y  = col_res.wrap ? down_y : caret_y_r;

  assign rep_last = (reps_r == 8'd1);
  assign in_grid  = (OPW'(item_r.read_col) < OPW'(cols_r)) &&
                    (OPW'(item_r.read_row) < OPW'(rows_r));

  // Register value clamping
  assign cols_clamp = (cfg_data == 8'd0) ? CNW'(1) :
                      (OPW'(cfg_data) > OPW'(MAX_COLS)) ? CNW'(MAX_COLS) :
                      CNW'(cfg_data);
  assign rows_clamp = (cfg_data[6:0] == 7'd0) ? RNW'(1) :
                      (OPW'(cfg_data[6:0]) > OPW'(MAX_ROWS)) ? RNW'(MAX_ROWS) :
                      RNW'(cfg_data[6:0]);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    caret_x_nxt   = caret_x_r;
    caret_y_nxt   = caret_y_r;
    scan_nxt      = scan_r;
    clr_addr_nxt  = clr_addr_r;
    reps_nxt      = reps_r;
    item_nxt      = item_r;
    cell_nxt      = cell_r;
    res_pend_nxt  = res_pend_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = {caret_y_r, caret_x_r};
    ram_wdata     = CH_SPACE;
    ram_raddr     = {caret_y_r, CW'(col_res.inc)};

    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == '1) begin
          res_pend_nxt = 1'b0;
          state_nxt    = res_pend_r ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          reps_nxt  = in_data.repeat_count;
          cell_nxt  = 8'd0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (item_r.mode)
          MODE_CHAR: begin
            if (reps_r == 8'd0) begin
              state_nxt = S_DONE;
            end else begin
              // one repeat of a typed character; most end the repeat here
              reps_nxt  = reps_r - 8'd1;
              state_nxt = rep_last ? S_DONE : S_EXEC;
              case (item_r.code)
                CH_BS: begin
                  if (!col_res.zero) begin
                    caret_x_nxt = CW'(col_res.dec);
                    scan_nxt    = CW'(col_res.dec);
                    reps_nxt    = reps_r;
                    state_nxt   = S_SH_RD;
                  end
                end
                CH_TAB: begin
                  reps_nxt  = reps_r;
                  state_nxt = S_TAB;
                end
                CH_LF: begin
                  caret_y_nxt = down_y;
                end
                CH_CR: begin
                  caret_x_nxt = '0;
                  caret_y_nxt = down_y;
                end
                CH_ESC: begin
                  // repeats of escape add nothing: one clearing pass
                  caret_x_nxt  = '0;
                  caret_y_nxt  = '0;
                  clr_addr_nxt = '0;
                  res_pend_nxt = 1'b1;
                  state_nxt    = S_CLEAR;
                end
                default: begin
                  ram_we      = 1'b1;
                  ram_wdata   = item_r.code;
                  caret_x_nxt = adv_x;
                  caret_y_nxt = adv_y;
                end
              endcase
            end
          end

          MODE_NAV: begin
            state_nxt = S_DONE;
            case (item_r.code)
              KEY_HOME:   caret_x_nxt = '0;
              KEY_END:    caret_x_nxt = CW'(col_res.lim_m1);
              KEY_TOP:    caret_y_nxt = '0;
              KEY_BOTTOM: caret_y_nxt = RW'(row_res.lim_m1);
              KEY_LEFT: begin
                if (!col_res.zero) caret_x_nxt = CW'(col_res.dec);
              end
              KEY_RIGHT: begin
                if (!col_res.wrap) caret_x_nxt = CW'(col_res.inc);
              end
              KEY_UP: begin
                if (!row_res.zero) caret_y_nxt = RW'(row_res.dec);
              end
              KEY_DOWN: begin
                if (!row_res.wrap) caret_y_nxt = RW'(row_res.inc);
              end
              KEY_DEL: begin
                scan_nxt  = caret_x_r;
                state_nxt = S_SH_RD;
              end
              default: ;
            endcase
          end

          MODE_READ: begin
            ram_raddr = {RW'(item_r.read_row), CW'(item_r.read_col)};
            state_nxt = in_grid ? S_READ : S_DONE;
          end

          default: state_nxt = S_DONE;
        endcase
      end

      // Tab: one space a cycle until the caret sits on a tab stop
      S_TAB: begin
        ram_we      = 1'b1;
        caret_x_nxt = adv_x;
        caret_y_nxt = adv_y;
        if (adv_x[TAB_BITS-1:0] == '0) begin
          reps_nxt  = reps_r - 8'd1;
          state_nxt = rep_last ? S_DONE : S_EXEC;
        end
      end

      // Delete: fetch the right neighbour, or pad the last column
      S_SH_RD: begin
        if (!col_res.wrap) begin
          state_nxt = S_SH_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = {caret_y_r, scan_r};
          if (item_r.mode == MODE_CHAR) begin
            reps_nxt  = reps_r - 8'd1;
            state_nxt = rep_last ? S_DONE : S_EXEC;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {caret_y_r, scan_r};
        ram_wdata = ram_rdata;
        scan_nxt  = CW'(col_res.inc);
        state_nxt = S_SH_RD;
      end

      S_READ: begin
        cell_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.caret_col  = 7'(caret_x_r);
        out_data_nxt.caret_row  = 6'(caret_y_r);
        out_data_nxt.cell_value = cell_r;
        state_nxt               = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Column and row register writes resize the grid: clear and home
    if (cfg_valid && cfg_ready && (cfg_index == CFG_COLS || cfg_index == CFG_ROWS)) begin
      if (cfg_index == CFG_COLS) begin
        cols_nxt = cols_clamp;
      end else begin
        rows_nxt = rows_clamp;
      end
      caret_x_nxt  = '0;
      caret_y_nxt  = '0;
      clr_addr_nxt = '0;
      state_nxt    = S_CLEAR;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      caret_x_r   <= '0;
      caret_y_r   <= '0;
      clr_addr_r  <= '0;
      res_pend_r  <= 1'b0;
      cols_r      <= CNW'(RST_COLS);
      rows_r      <= RNW'(RST_ROWS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      caret_x_r   <= caret_x_nxt;
      caret_y_r   <= caret_y_nxt;
      clr_addr_r  <= clr_addr_nxt;
      res_pend_r  <= res_pend_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    reps_r     <= reps_nxt;
    item_r     <= item_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  // Register writes only between items, and never beside an input beat
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== src/ttcb_checker.sv =====
// ----------------------------------------------------------------------------
// ttcb_checker
// Port-level checks of the text terminal, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic                        cfg_valid,
  input wire logic                        cfg_ready,
  input wire logic [ttcb_pkg::CFG_IW-1:0] cfg_index
);

  import ttcb_pkg::*;

  // Reset always starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // An accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // A register write starts the clearing pass
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == CFG_COLS || cfg_index == CFG_ROWS))
      |=> busy)
    else $error("register write did not start clearing");

  // Results are single strobes that close a busy spell
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

endmodule

bind text_terminal_char_buffer ttcb_checker u_ttcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);

`default_nettype wire

// ===== tb/sv/text_terminal_char_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// text_terminal_char_buffer_tb
// Self-checking bench for the character-cell text terminal. A short table of
// keystrokes and cell reads comes first, with a few hand-worked results,
// followed by random keystroke bursts under several grid sizes. Every result
// beat is compared field by field with a hand-worked result or a screen copy.
// ----------------------------------------------------------------------------
module text_terminal_char_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttcb_pkg::*;

  localparam int GRID_COLS      = 128;
  localparam int GRID_ROWS      = 64;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TABLE_LEN      = 27;

  // Codes with no name in the package
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_SPARE2  = 2'd2;
  localparam logic [1:0] CFG_SPARE3  = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_data;
  logic                out_valid;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [7:0]          cfg_data;

  text_terminal_char_buffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Screen copy: cells, caret and active grid size
  logic [7:0]  screen_cells [GRID_COLS*GRID_ROWS];
  int unsigned caret_x_m;
  int unsigned caret_y_m;
  int unsigned act_cols;
  int unsigned act_rows;

  out_item_t   screen_result_q [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // Directed rows: keystroke, hand-worked flag, hand-worked result
  typedef struct packed {
    in_item_t  key;
    logic      typed;
    out_item_t want;
  } key_row_t;

  key_row_t key_table [TABLE_LEN];

  function automatic void wipe_screen();
    foreach (screen_cells[i]) screen_cells[i] = CH_SPACE;
    caret_x_m = 0;
    caret_y_m = 0;
  endfunction

  function automatic void next_line();
    caret_y_m++;
    if (caret_y_m >= act_rows) caret_y_m = 0;
  endfunction

  function automatic void place_char(logic [7:0] c);
    screen_cells[caret_y_m*GRID_COLS + caret_x_m] = c;
    caret_x_m++;
    if (caret_x_m >= act_cols) begin
      caret_x_m = 0;
      next_line();
    end
  endfunction

  // Pull the rest of the caret's row one cell left, space at the far end
  function automatic void close_gap();
    int unsigned x;
    for (x = caret_x_m; x + 1 < act_cols; x++)
      screen_cells[caret_y_m*GRID_COLS + x] = screen_cells[caret_y_m*GRID_COLS + x + 1];
    screen_cells[caret_y_m*GRID_COLS + act_cols - 1] = CH_SPACE;
  endfunction

  // Apply one keystroke or read to the screen copy, give the result beat
  function automatic out_item_t terminal_step(in_item_t k);
    out_item_t r;
    r = '0;
    case (k.mode)
      MODE_CHAR: repeat (k.repeat_count) begin
        case (k.code)
          CH_BS: if (caret_x_m > 0) begin
            caret_x_m--;
            close_gap();
          end
          CH_TAB: do place_char(CH_SPACE); while (caret_x_m % (1 << TAB_BITS) != 0);
          CH_LF: next_line();
          CH_CR: begin
            caret_x_m = 0;
            next_line();
          end
          CH_ESC: wipe_screen();
          default: place_char(k.code);
        endcase
      end
      MODE_NAV: case (k.code)
        KEY_HOME:   caret_x_m = 0;
        KEY_END:    caret_x_m = act_cols - 1;
        KEY_TOP:    caret_y_m = 0;
        KEY_BOTTOM: caret_y_m = act_rows - 1;
        KEY_LEFT:   if (caret_x_m > 0) caret_x_m--;
        KEY_RIGHT:  if (caret_x_m + 1 < act_cols) caret_x_m++;
        KEY_UP:     if (caret_y_m > 0) caret_y_m--;
        KEY_DOWN:   if (caret_y_m + 1 < act_rows) caret_y_m++;
        KEY_DEL:    close_gap();
        default: ;
      endcase
      MODE_READ: if (k.read_col < act_cols && k.read_row < act_rows)
        r.cell_value = screen_cells[k.read_row*GRID_COLS + k.read_col];
      default: ;
    endcase
    r.caret_col = caret_x_m[6:0];
    r.caret_row = caret_y_m[5:0];
    return r;
  endfunction

  // Register write: clamp the size, clear the screen; spare indexes do nothing
  function automatic void apply_resize(logic [1:0] idx, logic [7:0] val);
    int unsigned v;
    case (idx)
      CFG_COLS: begin
        v = val;
        act_cols = (v == 0) ? 1 : (v > GRID_COLS) ? GRID_COLS : v;
        wipe_screen();
      end
      CFG_ROWS: begin
        v = val & 8'h7F;
        act_rows = (v == 0) ? 1 : (v > GRID_ROWS) ? GRID_ROWS : v;
        wipe_screen();
      end
      default: ;
    endcase
  endfunction

  // Mostly well-formed typing and navigation, some reads, a little noise
  function automatic in_item_t random_key();
    in_item_t    k;
    int unsigned pick;
    k = $bits(in_item_t)'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      k.mode = MODE_CHAR;
      pick = $urandom_range(0, 99);
      if (pick < 50)      k.code = 8'($urandom_range(8'h21, 8'h7E));
      else if (pick < 60) k.code = CH_BS;
      else if (pick < 68) k.code = CH_TAB;
      else if (pick < 74) k.code = CH_LF;
      else if (pick < 80) k.code = CH_CR;
      else if (pick < 84) k.code = CH_ESC;
      pick = $urandom_range(0, 99);
      if (pick < 70)      k.repeat_count = 8'($urandom_range(0, 4));
      else if (pick < 90) k.repeat_count = 8'($urandom_range(5, 40));
      // each escape costs a full clearing pass
      if (k.code == CH_ESC) k.repeat_count = 8'($urandom_range(0, 2));
    end else if (pick < 75) begin
      k.mode = MODE_NAV;
      if ($urandom_range(0, 9) != 0) k.code = 8'($urandom_range(KEY_HOME, KEY_DEL));
    end else if (pick < 95) begin
      k.mode = MODE_READ;
      if ($urandom_range(0, 3) != 0) begin
        k.read_col = 7'($urandom_range(0, act_cols - 1));
        k.read_row = 6'($urandom_range(0, act_rows - 1));
      end
    end else begin
      k.mode = MODE_UNUSED;
    end
    return k;
  endfunction

  // Present one beat, optionally after a random gap, and log its result
  task automatic send_key(in_item_t k, logic typed, out_item_t want, bit may_idle);
    out_item_t   model_res;
    int unsigned gap;
    gap = (may_idle && $urandom_range(0, 99) < 32) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= k;
    do @(posedge clk); while (busy !== 1'b0);
    model_res = terminal_step(k);
    screen_result_q.push_back(typed ? want : model_res);
  endtask

  task automatic type_burst(int unsigned n, bit may_idle);
    repeat (n) send_key(random_key(), 1'b0, '0, may_idle);
  endtask

  // Drop start and wait for every awaited beat to drain
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (screen_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_resize(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (screen_result_q.size() == 0) begin
        $display("%0t: unexpected result beat: col %0d row %0d cell %02h", $time,
                 out_data.caret_col, out_data.caret_row, out_data.cell_value);
        mismatches++;
      end else begin
        want = screen_result_q.pop_front();
        if (out_data.caret_col !== want.caret_col) begin
          $display("%0t: caret_col expected %0d, got %0d", $time,
                   want.caret_col, out_data.caret_col);
          mismatches++;
        end
        if (out_data.caret_row !== want.caret_row) begin
          $display("%0t: caret_row expected %0d, got %0d", $time,
                   want.caret_row, out_data.caret_row);
          mismatches++;
        end
        if (out_data.cell_value !== want.cell_value) begin
          $display("%0t: cell_value expected %02h, got %02h", $time,
                   want.cell_value, out_data.cell_value);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no beat moving on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    act_cols  = 80;
    act_rows  = 25;
    wipe_screen();

    // mode, code, repeats, read col, read row | typed | col, row, cell
    key_table[0]  = {MODE_READ, 8'h00,      8'd0,   7'd0,   6'd0,   1'b1, 7'd0,  6'd0,  CH_SPACE};
    key_table[1]  = {MODE_READ, 8'h00,      8'd0,   7'd127, 6'd63,  1'b1, 7'd0,  6'd0,  8'h00};
    key_table[2]  = {MODE_CHAR, 8'h41,      8'd1,   7'd0,   6'd0,   1'b1, 7'd1,  6'd0,  8'h00};
    key_table[3]  = {MODE_CHAR, 8'hFF,      8'd3,   7'd0,   6'd0,   1'b1, 7'd4,  6'd0,  8'h00};
    key_table[4]  = {MODE_CHAR, 8'h00,      8'd1,   7'd0,   6'd0,   1'b1, 7'd5,  6'd0,  8'h00};
    key_table[5]  = {MODE_CHAR, 8'h78,      8'd0,   7'd0,   6'd0,   1'b1, 7'd5,  6'd0,  8'h00};
    key_table[6]  = {MODE_CHAR, CH_TAB,     8'd1,   7'd0,   6'd0,   1'b1, 7'd8,  6'd0,  8'h00};
    key_table[7]  = {MODE_CHAR, CH_BS,      8'd2,   7'd0,   6'd0,   1'b1, 7'd6,  6'd0,  8'h00};
    key_table[8]  = {MODE_READ, 8'h00,      8'd0,   7'd1,   6'd0,   1'b0, 7'd0,  6'd0,  8'h00};
    key_table[9]  = {MODE_NAV,  KEY_HOME,   8'd0,   7'd0,   6'd0,   1'b1, 7'd0,  6'd0,  8'h00};
    key_table[10] = {MODE_NAV,  KEY_DEL,    8'd0,   7'd0,   6'd0,   1'b0, 7'd0,  6'd0,  8'h00};
    key_table[11] = {MODE_READ, 8'h00,      8'd0,   7'd0,   6'd0,   1'b0, 7'd0,  6'd0,  8'h00};
    key_table[12] = {MODE_NAV,  KEY_END,    8'd0,   7'd0,   6'd0,   1'b1, 7'd79, 6'd0,  8'h00};
    key_table[13] = {MODE_NAV,  KEY_RIGHT,  8'd0,   7'd0,   6'd0,   1'b1, 7'd79, 6'd0,  8'h00};
    key_table[14] = {MODE_CHAR, 8'h7A,      8'd1,   7'd0,   6'd0,   1'b1, 7'd0,  6'd1,  8'h00};
    key_table[15] = {MODE_NAV,  KEY_BOTTOM, 8'd0,   7'd0,   6'd0,   1'b1, 7'd0,  6'd24, 8'h00};
    key_table[16] = {MODE_NAV,  KEY_DOWN,   8'd0,   7'd0,   6'd0,   1'b1, 7'd0,  6'd24, 8'h00};
    key_table[17] = {MODE_NAV,  KEY_UP,     8'd0,   7'd0,   6'd0,   1'b1, 7'd0,  6'd23, 8'h00};
    key_table[18] = {MODE_NAV,  KEY_TOP,    8'd0,   7'd0,   6'd0,   1'b1, 7'd0,  6'd0,  8'h00};
    key_table[19] = {MODE_CHAR, CH_LF,      8'd1,   7'd0,   6'd0,   1'b1, 7'd0,  6'd1,  8'h00};
    key_table[20] = {MODE_NAV,  KEY_LEFT,   8'd0,   7'd0,   6'd0,   1'b1, 7'd0,  6'd1,  8'h00};
    key_table[21] = {MODE_NAV,  8'hFF,      8'd0,   7'd0,   6'd0,   1'b0, 7'd0,  6'd0,  8'h00};
    key_table[22] = {MODE_CHAR, CH_CR,      8'd1,   7'd0,   6'd0,   1'b0, 7'd0,  6'd0,  8'h00};
    key_table[23] = {MODE_UNUSED, 8'h55,    8'hAA,  7'h55,  6'h2A,  1'b0, 7'd0,  6'd0,  8'h00};
    key_table[24] = {MODE_CHAR, 8'h71,      8'd255, 7'd0,   6'd0,   1'b0, 7'd0,  6'd0,  8'h00};
    key_table[25] = {MODE_CHAR, CH_ESC,     8'd1,   7'd0,   6'd0,   1'b1, 7'd0,  6'd0,  8'h00};
    key_table[26] = {MODE_READ, 8'h00,      8'd0,   7'd79,  6'd24,  1'b1, 7'd0,  6'd0,  CH_SPACE};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed keystrokes on the reset grid
    foreach (key_table[i])
      send_key(key_table[i].key, key_table[i].typed, key_table[i].want, 1'b1);

    // Odd width, so tabs wrap short of a stop
    settle();
    write_reg(CFG_COLS, 8'd13);
    write_reg(CFG_ROWS, 8'd5);
    type_burst(12, 1'b1);

    // Zero sizes clamp to a single cell
    settle();
    write_reg(CFG_COLS, 8'd0);
    write_reg(CFG_ROWS, 8'd0);
    type_burst(6, 1'b1);

    // Oversize values clamp to the full store; pause mid-way till drained
    settle();
    write_reg(CFG_COLS, 8'hFF);
    write_reg(CFG_ROWS, 8'hFF);
    type_burst(8, 1'b1);
    settle();
    type_burst(8, 1'b1);

    // Row bit 7 is dropped, so 0x80 is one row; spare indexes keep the screen
    settle();
    write_reg(CFG_ROWS, 8'h80);
    type_burst(4, 1'b1);
    settle();
    write_reg(CFG_SPARE2, 8'h5A);
    write_reg(CFG_SPARE3, 8'hA5);
    type_burst(6, 1'b1);

    settle();
    write_reg(CFG_COLS, 8'd37);
    write_reg(CFG_ROWS, 8'd3);
    type_burst(10, 1'b1);

    settle();
    write_reg(CFG_COLS, 8'd1);
    write_reg(CFG_ROWS, 8'd100);
    type_burst(8, 1'b1);

    // Back-to-back beats on the default grid
    settle();
    write_reg(CFG_COLS, 8'd80);
    write_reg(CFG_ROWS, 8'd25);
    type_burst(30, 1'b0);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ttcb_pkg.sv
src/ttcb_ram.sv
src/ttcb_step.sv
src/text_terminal_char_buffer.sv
src/ttcb_checker.sv
tb/sv/text_terminal_char_buffer_tb.sv
